// ===== rtl/pva_pkg.sv =====
package pva_pkg;

  // voice pool and field widths
  localparam int NUM_VOICES = 24;
  localparam int MASK_BITS  = 24;
  localparam int PRIO_W     = 8;
  localparam int VOICE_W    = 5;
  localparam int VIDX_W     = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;

  // voices examined together in one group of the scan
  localparam int GROUP_SIZE = 8;
  localparam int NUM_GROUPS = (NUM_VOICES + GROUP_SIZE - 1) / GROUP_SIZE;

  // play request
  typedef struct packed {
    logic [PRIO_W-1:0]    request_priority;
    logic [MASK_BITS-1:0] active_mask;
  } req_t;

  // allocation result
  typedef struct packed {
    logic               granted;
    logic [VOICE_W-1:0] voice;
    logic               steal;
  } res_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } cmd_t;

endpackage

// ===== rtl/pva_ctrl.sv =====
module pva_ctrl
  import pva_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  output logic res_valid,
  input  logic res_stall,
  output cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_COMMIT
  } state_t;

  state_t state;

  // commands decoded from state
  always_comb begin
    cmd.load   = (state == S_IDLE) && req_valid;
    cmd.scan   = (state == S_SCAN);
    cmd.commit = (state == S_COMMIT) && (!res_valid || !res_stall);
  end

  assign req_stall = (state != S_IDLE);

  // state and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      if (cmd.commit) begin
        res_valid <= 1'b1;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd.load) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          state <= S_COMMIT;
        end
        S_COMMIT: begin
          if (cmd.commit) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // a loaded request is always scanned next
  a_load_then_scan: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> cmd.scan)
    else $error("scan did not follow load");

  // a commit always presents a result
  a_commit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> res_valid)
    else $error("result not presented after commit");

  // no new request while a result is being produced
  a_no_load_busy: assert property (@(posedge clk) disable iff (rst)
    (cmd.scan || cmd.commit) |-> req_stall)
    else $error("request accepted while busy");

endmodule

// ===== rtl/pva_datapath.sv =====
module pva_datapath
  import pva_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  req_t req,
  input  cmd_t cmd,
  output res_t res
);

  logic [PRIO_W-1:0]     tbl [NUM_VOICES];
  logic [PRIO_W-1:0]     prio;
  logic [NUM_VOICES-1:0] idle;

  logic                  grp_has_idle [NUM_GROUPS];
  logic [VIDX_W-1:0]     grp_idle_idx [NUM_GROUPS];
  logic [PRIO_W-1:0]     grp_min_p    [NUM_GROUPS];
  logic [VIDX_W-1:0]     grp_min_idx  [NUM_GROUPS];

  logic                  grp_has_idle_next [NUM_GROUPS];
  logic [VIDX_W-1:0]     grp_idle_idx_next [NUM_GROUPS];
  logic [PRIO_W-1:0]     grp_min_p_next    [NUM_GROUPS];
  logic [VIDX_W-1:0]     grp_min_idx_next  [NUM_GROUPS];

  logic [NUM_VOICES+MASK_BITS-1:0] mask_ext;
  logic [NUM_VOICES-1:0]           idle_in;

  logic              any_idle;
  logic [VIDX_W-1:0] idle_idx;
  logic [PRIO_W-1:0] min_p;
  logic [VIDX_W-1:0] min_idx;
  logic              steal;
  logic              granted;
  logic [VIDX_W-1:0] chosen;

  // voices beyond the mask count as idle
  assign mask_ext = {{NUM_VOICES{1'b0}}, req.active_mask};
  assign idle_in  = ~mask_ext[NUM_VOICES-1:0];

  // per group: first idle voice and lowest stored priority
  always_comb begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      grp_has_idle_next[g] = 1'b0;
      grp_idle_idx_next[g] = '0;
      grp_min_p_next[g]    = '0;
      grp_min_idx_next[g]  = '0;
      for (int j = 0; j < GROUP_SIZE; j++) begin
        if (g * GROUP_SIZE + j < NUM_VOICES) begin
          if (!grp_has_idle_next[g] && idle[g * GROUP_SIZE + j]) begin
            grp_has_idle_next[g] = 1'b1;
            grp_idle_idx_next[g] = VIDX_W'(g * GROUP_SIZE + j);
          end
          if (j == 0 || tbl[g * GROUP_SIZE + j] < grp_min_p_next[g]) begin
            grp_min_p_next[g]   = tbl[g * GROUP_SIZE + j];
            grp_min_idx_next[g] = VIDX_W'(g * GROUP_SIZE + j);
          end
        end
      end
    end
  end

  // across groups: lowest group wins ties
  always_comb begin
    any_idle = 1'b0;
    idle_idx = '0;
    min_p    = grp_min_p[0];
    min_idx  = grp_min_idx[0];
    for (int g = 0; g < NUM_GROUPS; g++) begin
      if (!any_idle && grp_has_idle[g]) begin
        any_idle = 1'b1;
        idle_idx = grp_idle_idx[g];
      end
      if (g > 0 && grp_min_p[g] < min_p) begin
        min_p   = grp_min_p[g];
        min_idx = grp_min_idx[g];
      end
    end
    steal   = !any_idle && (prio > min_p);
    granted = any_idle || steal;
    chosen  = any_idle ? idle_idx : min_idx;
  end

  // request capture, group results and result register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      prio <= req.request_priority;
      idle <= idle_in;
    end
    if (cmd.scan) begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
        grp_has_idle[g] <= grp_has_idle_next[g];
        grp_idle_idx[g] <= grp_idle_idx_next[g];
        grp_min_p[g]    <= grp_min_p_next[g];
        grp_min_idx[g]  <= grp_min_idx_next[g];
      end
    end
    if (cmd.commit) begin
      res.granted <= granted;
      res.voice   <= granted ? VOICE_W'(chosen) : '0;
      res.steal   <= steal;
    end
  end

  // priority table: idle voices cleared on load, chosen voice written on a granted commit
  always_ff @(posedge clk) begin
    for (int v = 0; v < NUM_VOICES; v++) begin
      if (rst) begin
        tbl[v] <= '0;
      end else if (cmd.load && idle_in[v]) begin
        tbl[v] <= '0;
      end else if (cmd.commit && granted && chosen == VIDX_W'(v)) begin
        tbl[v] <= prio;
      end
    end
  end

  // granted voice takes the request priority
  a_tbl_write: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && granted) |=> tbl[$past(chosen)] == $past(prio))
    else $error("table not updated for granted voice");

  // a steal is only ever a grant
  a_steal_granted: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && steal) |=> (res.granted && res.steal))
    else $error("steal without grant");

  // a steal only takes a voice of strictly lower priority
  a_steal_lower: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && steal) |-> (tbl[chosen] < prio))
    else $error("stolen voice not lower priority");

endmodule

// ===== rtl/priority_voice_allocator_core.sv =====
// Voice allocator with priority stealing. Each play request carries the sound's
// priority and the active-voice mask; voices shown idle have their stored
// priority cleared, the lowest-numbered idle voice is granted, and if none is
// idle the voice with the lowest stored priority (lowest index on ties) is
// stolen with a key-off flag, provided the request priority is strictly higher;
// otherwise the request is refused with all result fields zero. Exactly one
// result follows every request. A request is first captured, with idle voices
// cleared; the voices are then scanned in groups of eight, and the groups are
// combined and the priority table updated as the result is registered. The
// next request is taken the cycle after the result is registered, even while
// that result is still stalled, but no new request is taken before then; a
// result that is still waiting when the next request reaches its commit step
// holds that request until the result is taken.
module priority_voice_allocator_core
  import pva_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic res_valid,
  input  logic res_stall,
  output res_t res
);

  cmd_t cmd;

  // sequencing
  pva_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .cmd       (cmd)
  );

  // table, scan and result
  pva_datapath u_datapath (
    .clk (clk),
    .rst (rst),
    .req (req),
    .cmd (cmd),
    .res (res)
  );

endmodule
